// ===== rtl/tsee_pkg.sv =====
`timescale 1ns / 1ps
package tsee_pkg;
	localparam int StackDepth = 64;
	localparam int FracBits = 16;
	localparam int LvlW = $clog2(StackDepth + 1);
	localparam int AddrW = $clog2(StackDepth);
	localparam int DivSteps = 32 + FracBits;

	typedef enum logic [2:0] {
		FN_PUSH_OP = 3'd0,
		FN_PUSH_NUM = 3'd1,
		FN_POP_OP = 3'd2,
		FN_POP_NUM = 3'd3,
		FN_EVAL = 3'd4,
		FN_CLR_NUM = 3'd5,
		FN_CLR_OP = 3'd6,
		FN_NOP = 3'd7
	} func_t;

	localparam logic [7:0] ChLParen = 8'h28;
	localparam logic [7:0] ChPlus = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChStar = 8'h2A;
	localparam logic [7:0] ChSlash = 8'h2F;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_POP2,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_WAIT,
		ST_TOP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic pop2;
		logic mul;
		logic div_start;
		logic fin;
		logic top;
	} cmd_t;

	typedef struct packed {
		logic is_eval_arith;
		logic is_mul;
		logic is_div;
		logic div_done;
	} stat_t;
endpackage

// ===== rtl/tsee_ctrl.sv =====
`timescale 1ns / 1ps
module tsee_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic out_fire,
	input tsee_pkg::stat_t stat,
	output tsee_pkg::cmd_t cmd,
	output logic busy,
	output logic out_valid
);
	import tsee_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d = stat.is_eval_arith ? ST_POP2 : ST_WAIT;
			end
			ST_POP2: begin
				cmd.pop2 = 1'b1;
				if (stat.is_mul) state_d = ST_MUL;
				else if (stat.is_div) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else state_d = ST_FIN;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_DIV: if (stat.div_done) state_d = ST_FIN;
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: state_d = ST_TOP;
			ST_TOP: begin
				cmd.top = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== rtl/tsee_div.sv =====
`timescale 1ns / 1ps
module tsee_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [31:0] dividend,
	input logic signed [31:0] divisor,
	output logic done,
	output logic signed [31:0] quot,
	output logic sat
);
	import tsee_pkg::*;
	localparam int NW = 32 + FracBits;
	logic [NW-1:0] num_q, quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic neg_q, zero_q, dneg_q, run_q;
	logic [$clog2(DivSteps+1)-1:0] cnt_q;
	logic [33:0] trial;
	logic [32:0] shifted;
	logic [NW:0] sq;

	assign shifted = {rem_q[31:0], num_q[NW-1]};
	assign trial = {1'b0, shifted} - {2'b00, den_q};
	assign done = run_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= ($clog2(DivSteps+1))'(DivSteps);
		end else if (run_q) begin
			if (cnt_q == '0) run_q <= 1'b0;
			else cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {(dividend[31] ? 32'(-dividend) : 32'(dividend)), {FracBits{1'b0}}};
			den_q <= divisor[31] ? 32'(-divisor) : 32'(divisor);
			neg_q <= dividend[31] ^ divisor[31];
			dneg_q <= dividend[31];
			zero_q <= (divisor == '0);
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q && cnt_q != '0) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		sq = neg_q ? (NW+1)'(-{1'b0, quo_q}) : {1'b0, quo_q};
		sat = 1'b0;
		quot = sq[31:0];
		if (zero_q) begin
			sat = 1'b1;
			quot = dneg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else if (!neg_q && quo_q > NW'(32'h7FFF_FFFF)) begin
			sat = 1'b1;
			quot = 32'sh7FFF_FFFF;
		end else if (neg_q && quo_q > NW'(33'h8000_0000)) begin
			sat = 1'b1;
			quot = 32'sh8000_0000;
		end
	end
endmodule

// ===== rtl/tsee_dp.sv =====
`timescale 1ns / 1ps
module tsee_dp (
	input logic clk,
	input logic arst_n,
	input tsee_pkg::cmd_t cmd,
	input logic [2:0] func,
	input logic [7:0] op_char,
	input logic signed [31:0] number_in,
	output tsee_pkg::stat_t stat,
	output logic [7:0] popped_op,
	output logic signed [31:0] popped_num,
	output logic [7:0] top_op,
	output logic signed [31:0] top_num,
	output logic [6:0] num_depth,
	output logic ops_empty,
	output logic eval_ok,
	output logic saturated
);
	import tsee_pkg::*;
	logic [7:0] op_mem [StackDepth];
	logic [31:0] num_mem [StackDepth];
	logic [LvlW-1:0] op_lvl_q, num_lvl_q;
	func_t func_q;
	logic [7:0] ch_q, op_rd_q;
	logic [31:0] nin_q, n_rd_q, n_rd2_q;
	logic signed [31:0] first_q, res_q;
	logic signed [63:0] prod_q;
	logic [7:0] opx_q;
	logic push_res_q, ok_q, sat_q;
	logic [AddrW-1:0] op_ra, n_ra, n_ra2;
	logic div_done, div_sat;
	logic signed [31:0] div_q;
	logic signed [33:0] asum;
	logic signed [63:0] mq;

	assign op_ra = AddrW'(op_lvl_q - 1'b1);
	assign n_ra = AddrW'(num_lvl_q - 1'b1);
	assign n_ra2 = AddrW'(num_lvl_q - 2'd2);

	always_ff @(posedge clk) begin
		op_rd_q <= op_mem[op_ra];
		n_rd_q <= num_mem[n_ra];
		n_rd2_q <= num_mem[n_ra2];
		if (cmd.exec && func_q == FN_PUSH_OP && op_lvl_q < LvlW'(StackDepth))
			op_mem[AddrW'(op_lvl_q)] <= ch_q;
		if (cmd.exec && func_q == FN_PUSH_NUM && num_lvl_q < LvlW'(StackDepth))
			num_mem[AddrW'(num_lvl_q)] <= nin_q;
		if (cmd.fin && push_res_q) num_mem[AddrW'(num_lvl_q)] <= res_q;
	end

	assign stat.is_eval_arith = func_q == FN_EVAL && op_lvl_q != '0 &&
		num_lvl_q >= LvlW'(2) && op_rd_q != ChLParen;
	assign stat.is_mul = opx_q == ChStar;
	assign stat.is_div = opx_q == ChSlash;
	assign stat.div_done = div_done;

	tsee_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend($signed(n_rd2_q)), .divisor(first_q),
		.done(div_done), .quot(div_q), .sat(div_sat)
	);

	assign asum = (opx_q == ChMinus) ? 34'(signed'(n_rd2_q)) - 34'(first_q)
		: 34'(signed'(n_rd2_q)) + 34'(first_q);
	assign mq = prod_q >>> FracBits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_lvl_q <= '0;
			num_lvl_q <= '0;
		end else if (cmd.exec) begin
			unique case (func_q)
				FN_PUSH_OP: if (op_lvl_q < LvlW'(StackDepth)) op_lvl_q <= op_lvl_q + 1'b1;
				FN_PUSH_NUM: if (num_lvl_q < LvlW'(StackDepth)) num_lvl_q <= num_lvl_q + 1'b1;
				FN_POP_OP: if (op_lvl_q != '0) op_lvl_q <= op_lvl_q - 1'b1;
				FN_POP_NUM: if (num_lvl_q != '0) num_lvl_q <= num_lvl_q - 1'b1;
				FN_EVAL: if (op_lvl_q != '0 && num_lvl_q >= LvlW'(2)) begin
					op_lvl_q <= op_lvl_q - 1'b1;
					if (op_rd_q != ChLParen) num_lvl_q <= num_lvl_q - LvlW'(2);
				end
				FN_CLR_NUM: num_lvl_q <= '0;
				FN_CLR_OP: op_lvl_q <= '0;
				default: ;
			endcase
		end else if (cmd.fin && push_res_q) num_lvl_q <= num_lvl_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(func);
			ch_q <= op_char;
			nin_q <= number_in;
		end
		if (cmd.exec) begin
			popped_op <= (func_q == FN_POP_OP && op_lvl_q != '0) ? op_rd_q : 8'd0;
			popped_num <= (func_q == FN_POP_NUM && num_lvl_q != '0) ? n_rd_q : 32'd0;
			ok_q <= stat.is_eval_arith;
			sat_q <= 1'b0;
			opx_q <= op_rd_q;
			first_q <= n_rd_q;
			push_res_q <= 1'b0;
		end
		if (cmd.pop2) begin
			prod_q <= 64'(signed'(n_rd2_q)) * 64'(first_q);
			push_res_q <= opx_q == ChPlus || opx_q == ChMinus || opx_q == ChStar ||
				opx_q == ChSlash;
			if (opx_q == ChPlus || opx_q == ChMinus) begin
				if (asum > 34'sh7FFF_FFFF) begin
					res_q <= 32'sh7FFF_FFFF;
					sat_q <= 1'b1;
				end else if (asum < -34'sh8000_0000) begin
					res_q <= 32'sh8000_0000;
					sat_q <= 1'b1;
				end else res_q <= asum[31:0];
			end
		end
		if (cmd.mul) begin
			if (mq > 64'sh7FFF_FFFF) begin
				res_q <= 32'sh7FFF_FFFF;
				sat_q <= 1'b1;
			end else if (mq < -64'sh8000_0000) begin
				res_q <= 32'sh8000_0000;
				sat_q <= 1'b1;
			end else res_q <= mq[31:0];
		end
		if (div_done) begin
			res_q <= div_q;
			sat_q <= div_sat;
		end
		if (cmd.top) begin
			top_op <= (op_lvl_q != '0) ? op_rd_q : 8'd0;
			top_num <= (num_lvl_q != '0) ? n_rd_q : 32'd0;
			num_depth <= 7'(num_lvl_q);
			ops_empty <= op_lvl_q == '0;
			eval_ok <= ok_q;
			saturated <= sat_q;
		end
	end
endmodule

// ===== rtl/two_stack_expression_evaluator.sv =====
`timescale 1ns / 1ps
// Two-stack expression evaluator: an operator stack and a Q16.16 number stack.
// Commands arrive on the s_axis channel, one command per transaction; tdata
// carries func, op_char and number_in. Each command yields exactly one
// result transaction on m_axis with the popped values, the stack tops,
// the number depth and the evaluate status flags.
// One command is processed at a time: it is registered, then executed on the
// registered stack reads. An evaluate that applies an operator pops both
// operands, adds or subtracts, multiplies, or divides on the bit-serial
// divider that retires one quotient bit per cycle over 48 steps, and pushes
// the result for +, -, * or /. Stack reads go through registered memory
// ports; the tops and flags are then registered and put on m_axis. After a
// result transaction the controller returns to idle for the next command.
// Reset clears both stack levels and returns the controller to idle; stack
// contents are not cleared. s_axis_tready is low while a command is in work.
// When the receiver holds m_axis_tready low, the result stays on m_axis and
// no new command is taken until that result transaction completes.
module two_stack_expression_evaluator (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// func[2:0], op_char[10:3], number_in[42:11], zero fill to 47
	input logic [47:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// popped_op[7:0], popped_num[39:8], top_op[47:40], top_num[79:48],
	// num_depth[86:80], ops_empty[87], eval_ok[88], saturated[89], zero fill
	output logic [95:0] m_axis_tdata
);
	import tsee_pkg::*;
	cmd_t cmd;
	stat_t stat;
	logic busy, in_fire, out_fire;
	logic [7:0] popped_op, top_op;
	logic signed [31:0] popped_num, top_num;
	logic [6:0] num_depth;
	logic ops_empty, eval_ok, saturated;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	tsee_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.stat(stat), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
	);

	tsee_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.func(s_axis_tdata[2:0]), .op_char(s_axis_tdata[10:3]),
		.number_in(s_axis_tdata[42:11]), .stat(stat),
		.popped_op(popped_op), .popped_num(popped_num), .top_op(top_op),
		.top_num(top_num), .num_depth(num_depth), .ops_empty(ops_empty),
		.eval_ok(eval_ok), .saturated(saturated)
	);

	assign m_axis_tdata = {6'd0, saturated, eval_ok, ops_empty, num_depth, top_num,
		top_op, popped_num, popped_op};
endmodule

// ===== rtl/tsee_checker.sv =====
`timescale 1ns / 1ps
module tsee_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [95:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("accepting while result pending");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("double accept");
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[86:80] <= 7'd64) else $error("depth out of range");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[89] |-> m_axis_tdata[88]) else $error("sat without ok");
endmodule

bind two_stack_expression_evaluator tsee_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ===== dv/tb_two_stack_expression_evaluator.sv =====
`timescale 1ns / 1ps
module tb_two_stack_expression_evaluator;
	import tsee_pkg::*;

	typedef struct {
		logic [2:0] func;
		logic [7:0] op_char;
		logic [31:0] number_in;
	} cmd_item_t;

	typedef struct {
		logic [7:0] popped_op;
		logic [31:0] popped_num;
		logic [7:0] top_op;
		logic [31:0] top_num;
		logic [6:0] num_depth;
		logic ops_empty;
		logic eval_ok;
		logic saturated;
	} stack_status_t;

	localparam int WatchdogLimit = 20000;
	localparam int HoldOffCycles = 400;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [95:0] m_axis_tdata;

	two_stack_expression_evaluator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	cmd_item_t pending_cmds[$];
	stack_status_t expected_status[$];
	logic [7:0] op_mem[StackDepth];
	logic [31:0] num_mem[StackDepth];
	int op_lvl;
	int num_lvl;
	int fail_count;
	int accepted_cmds;
	int checked_results;
	int idle_cycles;
	bit stim_done;
	bit tail_phase;
	bit hold_off;
	bit hold_used;
	int src_gap;
	int snk_gap;
	int hold_count;
	int eval_count;
	int sat_count;

	function automatic logic [31:0] clamp_q(input longint v, inout logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'h7FFFFFFF;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic stack_status_t apply_command(input cmd_item_t c);
		stack_status_t r;
		logic [7:0] opc;
		longint a;
		longint b;
		longint p;
		logic sat;
		r = '{default: '0};
		sat = 1'b0;
		case (c.func)
			FN_PUSH_OP: begin
				if (op_lvl < StackDepth) begin
					op_mem[op_lvl] = c.op_char;
					op_lvl++;
				end
			end
			FN_PUSH_NUM: begin
				if (num_lvl < StackDepth) begin
					num_mem[num_lvl] = c.number_in;
					num_lvl++;
				end
			end
			FN_POP_OP: begin
				if (op_lvl > 0) begin
					op_lvl--;
					r.popped_op = op_mem[op_lvl];
				end
			end
			FN_POP_NUM: begin
				if (num_lvl > 0) begin
					num_lvl--;
					r.popped_num = num_mem[num_lvl];
				end
			end
			FN_EVAL: begin
				if (op_lvl > 0 && num_lvl >= 2) begin
					if (op_mem[op_lvl - 1] == ChLParen) begin
						op_lvl--;
					end else begin
						op_lvl--;
						opc = op_mem[op_lvl];
						b = longint'($signed(num_mem[num_lvl - 1]));
						a = longint'($signed(num_mem[num_lvl - 2]));
						num_lvl -= 2;
						r.eval_ok = 1'b1;
						if (opc == ChPlus || opc == ChMinus || opc == ChStar
								|| opc == ChSlash) begin
							if (opc == ChPlus) begin
								p = a + b;
							end else if (opc == ChMinus) begin
								p = a - b;
							end else if (opc == ChStar) begin
								p = (a * b) >>> FracBits;
							end else if (b == 0) begin
								sat = 1'b1;
								p = (a < 0) ? -64'sd2147483648 : 64'sd2147483647;
							end else begin
								p = (a * (64'sd1 << FracBits)) / b;
							end
							num_mem[num_lvl] = clamp_q(p, sat);
							num_lvl++;
						end
					end
				end
			end
			FN_CLR_NUM: num_lvl = 0;
			FN_CLR_OP: op_lvl = 0;
			default: ;
		endcase
		r.top_op = (op_lvl > 0) ? op_mem[op_lvl - 1] : 8'd0;
		r.top_num = (num_lvl > 0) ? num_mem[num_lvl - 1] : 32'd0;
		r.num_depth = num_lvl[6:0];
		r.ops_empty = (op_lvl == 0);
		r.saturated = sat;
		return r;
	endfunction

	function automatic cmd_item_t mk(input logic [2:0] f, input logic [7:0] ch,
			input logic [31:0] n);
		cmd_item_t c;
		c.func = f;
		c.op_char = ch;
		c.number_in = n;
		return c;
	endfunction

	function automatic logic [31:0] rand_num();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'd0;
			3: return $urandom_range(0, 8) << 16;
			4: return -($urandom_range(0, 8) << 16);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 9))
			0, 1: return ChPlus;
			2, 3: return ChMinus;
			4, 5: return ChStar;
			6, 7: return ChSlash;
			8: return ChLParen;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int k;
		int j;
		arst_n = 1'b0;
		pending_cmds.push_back(mk(FN_POP_OP, 8'hFF, 32'hFFFFFFFF));
		pending_cmds.push_back(mk(FN_POP_NUM, 8'h00, 32'h0));
		pending_cmds.push_back(mk(FN_EVAL, 8'h00, 32'h0));
		pending_cmds.push_back(mk(FN_PUSH_NUM, 8'h00, 32'h7FFFFFFF));
		pending_cmds.push_back(mk(FN_PUSH_NUM, 8'h00, 32'h7FFFFFFF));
		pending_cmds.push_back(mk(FN_EVAL, 8'h00, 32'h0));
		pending_cmds.push_back(mk(FN_PUSH_OP, ChPlus, 32'h0));
		pending_cmds.push_back(mk(FN_EVAL, 8'h00, 32'h0));
		pending_cmds.push_back(mk(FN_PUSH_NUM, 8'h00, 32'h80000000));
		pending_cmds.push_back(mk(FN_PUSH_NUM, 8'h00, 32'h0));
		pending_cmds.push_back(mk(FN_PUSH_OP, ChSlash, 32'h0));
		pending_cmds.push_back(mk(FN_EVAL, 8'h00, 32'h0));
		pending_cmds.push_back(mk(FN_PUSH_NUM, 8'h00, 32'hFFFF8000));
		pending_cmds.push_back(mk(FN_PUSH_OP, ChStar, 32'h0));
		pending_cmds.push_back(mk(FN_EVAL, 8'h00, 32'h0));
		pending_cmds.push_back(mk(FN_PUSH_NUM, 8'h00, 32'h00030000));
		pending_cmds.push_back(mk(FN_PUSH_OP, ChLParen, 32'h0));
		pending_cmds.push_back(mk(FN_EVAL, 8'h00, 32'h0));
		pending_cmds.push_back(mk(FN_PUSH_OP, 8'hFF, 32'h0));
		pending_cmds.push_back(mk(FN_EVAL, 8'h00, 32'h0));
		pending_cmds.push_back(mk(FN_PUSH_OP, ChMinus, 32'h0));
		pending_cmds.push_back(mk(FN_NOP, 8'h55, 32'hAAAAAAAA));
		pending_cmds.push_back(mk(FN_CLR_OP, 8'h00, 32'h0));
		pending_cmds.push_back(mk(FN_CLR_NUM, 8'h00, 32'h0));
		for (k = 0; k < 66; k++) begin
			pending_cmds.push_back(mk(FN_PUSH_NUM, 8'h00, $urandom));
			pending_cmds.push_back(mk(FN_PUSH_OP, 8'($urandom_range(0, 255)), 32'h0));
		end
		pending_cmds.push_back(mk(FN_CLR_NUM, 8'h00, 32'h0));
		pending_cmds.push_back(mk(FN_CLR_OP, 8'h00, 32'h0));
		while (pending_cmds.size() < 550) begin
			if ($urandom_range(0, 3) != 0) begin
				for (j = 0; j < 2; j++) begin
					pending_cmds.push_back(mk(FN_PUSH_NUM, 8'($urandom), rand_num()));
				end
				pending_cmds.push_back(mk(FN_PUSH_OP, rand_op(), $urandom));
				pending_cmds.push_back(mk(FN_EVAL, 8'($urandom), $urandom));
				if ($urandom_range(0, 3) == 0) begin
					pending_cmds.push_back(mk(FN_POP_NUM, 8'($urandom), $urandom));
				end
			end else begin
				pending_cmds.push_back(mk(3'($urandom_range(0, 7)), 8'($urandom),
					rand_num()));
			end
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			src_gap <= 0;
			accepted_cmds <= 0;
			stim_done <= 1'b0;
			op_lvl = 0;
			num_lvl = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				accepted_cmds <= accepted_cmds + 1;
				expected_status.push_back(apply_command(mk(s_axis_tdata[2:0],
					s_axis_tdata[10:3], s_axis_tdata[42:11])));
				void'(pending_cmds.pop_front());
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (!tail_phase && !hold_off && $urandom_range(0, 15) == 0) begin
					src_gap <= $urandom_range(1, 18) - 1;
					s_axis_tvalid <= 1'b0;
				end else begin
					if (s_axis_tvalid && s_axis_tready) begin
						if (pending_cmds.size() > 0) begin
							s_axis_tvalid <= 1'b1;
							s_axis_tdata <= {5'd0, pending_cmds[0].number_in,
								pending_cmds[0].op_char, pending_cmds[0].func};
						end else begin
							s_axis_tvalid <= 1'b0;
							stim_done <= 1'b1;
						end
					end else if (pending_cmds.size() > 0) begin
						s_axis_tvalid <= 1'b1;
						s_axis_tdata <= {5'd0, pending_cmds[0].number_in,
							pending_cmds[0].op_char, pending_cmds[0].func};
					end else begin
						s_axis_tvalid <= 1'b0;
						stim_done <= 1'b1;
					end
				end
			end
		end
	end

	assign tail_phase = accepted_cmds > 470;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_gap <= 0;
			hold_count <= 0;
			hold_off <= 1'b0;
			hold_used <= 1'b0;
			fail_count <= 0;
			checked_results <= 0;
			eval_count <= 0;
			sat_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				stack_status_t e;
				stack_status_t a;
				a.popped_op = m_axis_tdata[7:0];
				a.popped_num = m_axis_tdata[39:8];
				a.top_op = m_axis_tdata[47:40];
				a.top_num = m_axis_tdata[79:48];
				a.num_depth = m_axis_tdata[86:80];
				a.ops_empty = m_axis_tdata[87];
				a.eval_ok = m_axis_tdata[88];
				a.saturated = m_axis_tdata[89];
				checked_results <= checked_results + 1;
				if (expected_status.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_status.pop_front();
					eval_count <= eval_count + e.eval_ok;
					sat_count <= sat_count + e.saturated;
					if (a.popped_op !== e.popped_op) begin
						$error("popped_op exp %0h got %0h", e.popped_op, a.popped_op);
						fail_count <= fail_count + 1;
					end
					if (a.popped_num !== e.popped_num) begin
						$error("popped_num exp %0h got %0h", e.popped_num, a.popped_num);
						fail_count <= fail_count + 1;
					end
					if (a.top_op !== e.top_op) begin
						$error("top_op exp %0h got %0h", e.top_op, a.top_op);
						fail_count <= fail_count + 1;
					end
					if (a.top_num !== e.top_num) begin
						$error("top_num exp %0h got %0h", e.top_num, a.top_num);
						fail_count <= fail_count + 1;
					end
					if (a.num_depth !== e.num_depth) begin
						$error("num_depth exp %0d got %0d", e.num_depth, a.num_depth);
						fail_count <= fail_count + 1;
					end
					if (a.ops_empty !== e.ops_empty) begin
						$error("ops_empty exp %0b got %0b", e.ops_empty, a.ops_empty);
						fail_count <= fail_count + 1;
					end
					if (a.eval_ok !== e.eval_ok) begin
						$error("eval_ok exp %0b got %0b", e.eval_ok, a.eval_ok);
						fail_count <= fail_count + 1;
					end
					if (a.saturated !== e.saturated) begin
						$error("saturated exp %0b got %0b", e.saturated, a.saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (accepted_cmds == 300 && !hold_used && !hold_off) begin
				hold_off <= 1'b1;
				hold_used <= 1'b1;
				hold_count <= HoldOffCycles;
				m_axis_tready <= 1'b0;
			end else if (hold_off) begin
				if (hold_count == 1) begin
					hold_off <= 1'b0;
				end
				hold_count <= hold_count - 1;
				m_axis_tready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (!tail_phase && $urandom_range(0, 12) == 0) begin
				snk_gap <= $urandom_range(1, 18) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		@(posedge arst_n);
		while (!(stim_done && expected_status.size() == 0)) begin
			@(posedge clk);
			if (idle_cycles >= WatchdogLimit) begin
				$display("watchdog expired with %0d results outstanding",
					expected_status.size());
				$display("TEST FAILED");
				$finish;
			end
		end
		repeat (100) @(posedge clk);
		$display("Ran %0d commands, checked %0d results: %0d evaluations, %0d saturated.",
			accepted_cmds, checked_results, eval_count, sat_count);
		$display("Covered empty pops, full stacks, all operators and a long output stall.");
		if (fail_count == 0 && expected_status.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
